/* hdl/lsj_pkg.sv */
// ----------------------------------------------------------------------------
// lsj_pkg
// Shared types, constants and coefficient table of the Lissajous scan block.
// ----------------------------------------------------------------------------
package lsj_pkg;

  // configuration register indexes
  localparam logic [2:0] REG_PAN_AMP  = 3'd0;
  localparam logic [2:0] REG_TILT_AMP = 3'd1;
  localparam logic [2:0] REG_PAN_OFF  = 3'd2;
  localparam logic [2:0] REG_TILT_OFF = 3'd3;
  localparam logic [2:0] REG_SPEED    = 3'd4;

  localparam logic [19:0] MIN_ELAPSED_US  = 20'd1000;
  localparam int          ANGLE_FRAC_BITS = 16;

  // 32-bit turn phase constants
  localparam logic [31:0] QUARTER32     = 32'h4000_0000;
  localparam logic [31:0] STEP_PAN32    = 32'd683565;
  localparam logic [31:0] STEP_TILT32   = 32'd2051663;
  localparam logic [31:0] FREQ_FRAC32   = 32'd6074001;
  localparam logic [31:0] RESTART_PAN32 = 32'd357745299;
  localparam logic [31:0] SPEED_K_Q4    = 32'd179193;
  localparam logic [31:0] SEC_TO_TURN   = 32'd44798134;

  // sine polynomial coefficients, Q30
  localparam logic [31:0] SIN_C1 = 32'd1686629713;
  localparam logic [31:0] SIN_C3 = 32'd693598669;
  localparam logic [31:0] SIN_C5 = 32'd85569305;
  localparam logic [31:0] SIN_C7 = 32'd5026995;
  localparam logic [31:0] SIN_C9 = 32'd172272;

  localparam logic signed [19:0] ANGLE_MAX = 20'sh7FFFF;
  localparam logic signed [19:0] ANGLE_MIN = 20'sh80000;

  typedef enum logic [4:0] {
    ST_IDLE, ST_SIN0, ST_SIN1, ST_HORN, ST_SINF,
    ST_D1, ST_D2, ST_SQ1, ST_SQ2, ST_SQI, ST_SQRT,
    ST_ADV0, ST_ADVZ, ST_ADV1, ST_ADV2, ST_ADV3, ST_DIV,
    ST_TADV, ST_UPD, ST_A1, ST_A2, ST_A3, ST_DONE
  } lsj_st_e;

  typedef struct packed {
    logic [18:0]        pan_amp;
    logic [18:0]        tilt_amp;
    logic signed [19:0] pan_off;
    logic signed [19:0] tilt_off;
    logic [23:0]        speed;
  } lsj_cfg_t;

  typedef struct packed {
    logic signed [19:0] pan;
    logic signed [19:0] tilt;
    logic               skipped;
  } lsj_res_t;

  typedef struct packed {
    logic busy;
    logic res_valid;
  } lsj_stat_t;

  // horner coefficients after the degree-9 term
  function automatic logic [31:0] lsj_coef(input logic [1:0] idx);
    logic [31:0] c;
    case (idx)
      2'd0:    c = SIN_C7;
      2'd1:    c = SIN_C5;
      2'd2:    c = SIN_C3;
      default: c = SIN_C1;
    endcase
    return c;
  endfunction

endpackage

/* hdl/lsj_mul.sv */
// ----------------------------------------------------------------------------
// lsj_mul
// Shared 32x32 unsigned multiplier with registered product.
// ----------------------------------------------------------------------------
module lsj_mul (
  input  logic        clk_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic [63:0] p_o
);

  logic [63:0] p_q;

  // one product per cycle
  always_ff @(posedge clk_i) begin
    p_q <= 64'(a_i) * 64'(b_i);
  end

  assign p_o = p_q;

endmodule

/* hdl/lsj_core.sv */
// ----------------------------------------------------------------------------
// lsj_core
// Sequencer and datapath: sine evaluation, speed estimate, square root,
// division and phase update, all over one shared multiplier and subtractor.
// ----------------------------------------------------------------------------
module lsj_core import lsj_pkg::*; #(
  parameter int PHASE_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        mode_i,
  input  logic [19:0] elapsed_us_i,
  input  lsj_cfg_t    cfg_i,
  input  logic        res_take_i,
  output lsj_stat_t   stat_o,
  output lsj_res_t    res_o
);

  localparam int SHL = (PHASE_BITS >= 32) ? PHASE_BITS - 32 : 0;
  localparam int SHR = (PHASE_BITS >= 32) ? 0 : 32 - PHASE_BITS;

  function automatic logic [PHASE_BITS-1:0] to_pb(input logic [33:0] x);
    logic [49:0] w;
    w = (50'(x) << SHL) >> SHR;
    return w[PHASE_BITS-1:0];
  endfunction

  function automatic logic [31:0] from_pb(input logic [PHASE_BITS-1:0] p);
    logic [63:0] w;
    w = (64'(p) >> SHL) << SHR;
    return w[31:0];
  endfunction

  lsj_st_e st_q, st_d;

  logic [PHASE_BITS-1:0] pan_ph_q, tilt_ph_q;
  logic [2:0]            sl_q;
  logic [4:0]            cnt_q;
  logic                  mode_q, skip_q;
  logic [19:0]           el_q;
  logic [30:0]           x_q, x2_q;
  logic                  neg_q;
  logic signed [31:0]    s_q [6];
  logic [31:0]           d1_q, d2_q;
  logic [63:0]           acc_q, v_q, res_q, bit_q;
  logic [31:0]           ph_q, rem_q, quo_q, adv_q;
  lsj_res_t              out_q;

  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;
  logic [64:0] sub_a, sub_b, sub_r;
  logic        ge;

  lsj_mul u_mul (.clk_i(clk_i), .a_i(mul_a), .b_i(mul_b), .p_o(prod));

  // shared subtractor for root and divide steps
  assign sub_r = sub_a - sub_b;
  assign ge    = ~sub_r[64];

  // helper values
  logic [31:0] p32, t32, ph_sel, pn, m;
  logic [30:0] x_new;
  logic [32:0] dif1, dif2;
  logic [31:0] adif1, adif2, as4, as5;
  logic [63:0] n_sum, rnd_pan, rnd_tilt;
  logic [25:0] np_hi;
  logic [31:0] np_lo, r2lo;
  logic [32:0] r2;
  logic [33:0] tadv;
  logic [63:0] frac_w;
  logic signed [23:0] pan_sum, tilt_sum;
  logic [21:0] rr;

  assign p32 = from_pb(pan_ph_q);
  assign t32 = from_pb(tilt_ph_q);
  assign m   = res_q[31:0];

  // phase for the sine slot in work
  always_comb begin
    case (sl_q)
      3'd0:    ph_sel = p32 + STEP_PAN32;
      3'd1:    ph_sel = p32;
      3'd2:    ph_sel = t32 + STEP_TILT32 + QUARTER32;
      3'd3:    ph_sel = t32 + QUARTER32;
      3'd4:    ph_sel = p32;
      default: ph_sel = t32 + QUARTER32;
    endcase
  end

  // quadrant fold
  assign x_new = ph_sel[30] ? 31'(QUARTER32) - {1'b0, ph_sel[29:0]}
                            : {1'b0, ph_sel[29:0]};
  assign pn    = lsj_coef(cnt_q[1:0]) - prod[61:30];

  assign dif1  = {s_q[0][31], s_q[0]} - {s_q[1][31], s_q[1]};
  assign dif2  = {s_q[2][31], s_q[2]} - {s_q[3][31], s_q[3]};
  assign adif1 = dif1[32] ? 32'(-dif1) : dif1[31:0];
  assign adif2 = dif2[32] ? 32'(-dif2) : dif2[31:0];
  assign as4   = s_q[4][31] ? 32'(-s_q[4]) : 32'(s_q[4]);
  assign as5   = s_q[5][31] ? 32'(-s_q[5]) : 32'(s_q[5]);

  assign n_sum = acc_q + {prod[31:0], 32'd0};
  assign np_hi = n_sum[61:36];
  assign np_lo = n_sum[35:4];
  assign r2    = {rem_q, quo_q[31]};
  assign r2lo  = r2[31:0];

  assign frac_w = prod + 64'h8000_0000;
  assign tadv   = {2'b00, adv_q} + {1'b0, adv_q, 1'b0} + {11'd0, frac_w[54:32]};

  // amplitude times sine, rounded half away from zero, plus offset
  assign rnd_pan  = prod + (64'd1 << 29);
  assign rnd_tilt = prod + (64'd1 << 29);
  assign rr       = (st_q == ST_A2) ? rnd_pan[51:30] : rnd_tilt[51:30];
  assign pan_sum  = 24'(cfg_i.pan_off) +
                    (s_q[4][31] ? -$signed({2'b00, rr}) : $signed({2'b00, rr}));
  assign tilt_sum = 24'(cfg_i.tilt_off) +
                    (s_q[5][31] ? -$signed({2'b00, rr}) : $signed({2'b00, rr}));

  function automatic logic signed [19:0] sat20(input logic signed [23:0] v);
    logic signed [19:0] r;
    if (v > 24'(ANGLE_MAX)) begin
      r = ANGLE_MAX;
    end else if (v < 24'(ANGLE_MIN)) begin
      r = ANGLE_MIN;
    end else begin
      r = v[19:0];
    end
    return r;
  endfunction

  // next state
  always_comb begin
    st_d = st_q;
    case (st_q)
      ST_IDLE: begin
        if (start_i) begin
          st_d = ST_SIN0;
        end
      end
      ST_SIN0: st_d = ST_SIN1;
      ST_SIN1: st_d = ST_HORN;
      ST_HORN: begin
        if (cnt_q[1:0] == 2'd3) begin
          st_d = ST_SINF;
        end
      end
      ST_SINF: begin
        if (sl_q == 3'd3) begin
          st_d = ST_D1;
        end else if (sl_q == 3'd5) begin
          st_d = ST_A1;
        end else begin
          st_d = ST_SIN0;
        end
      end
      ST_D1:   st_d = ST_D2;
      ST_D2:   st_d = ST_SQ1;
      ST_SQ1:  st_d = ST_SQ2;
      ST_SQ2:  st_d = ST_SQI;
      ST_SQI:  st_d = ST_SQRT;
      ST_SQRT: begin
        if (cnt_q == 5'd31) begin
          st_d = ST_ADV0;
        end
      end
      ST_ADV0: st_d = (m == 32'd0) ? ST_ADVZ : ST_ADV1;
      ST_ADVZ: st_d = ST_TADV;
      ST_ADV1: st_d = ST_ADV2;
      ST_ADV2: st_d = ST_ADV3;
      ST_ADV3: st_d = ge ? ST_TADV : ST_DIV;
      ST_DIV: begin
        if (cnt_q == 5'd31) begin
          st_d = ST_TADV;
        end
      end
      ST_TADV: st_d = ST_UPD;
      ST_UPD:  st_d = ST_SIN0;
      ST_A1:   st_d = ST_A2;
      ST_A2:   st_d = ST_A3;
      ST_A3:   st_d = ST_DONE;
      ST_DONE: begin
        if (res_take_i) begin
          st_d = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  // unit operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    sub_a = '0;
    sub_b = '0;
    case (st_q)
      ST_SIN0: begin
        mul_a = {1'b0, x_new};
        mul_b = {1'b0, x_new};
      end
      ST_SIN1: begin
        mul_a = SIN_C9;
        mul_b = {1'b0, prod[60:30]};
      end
      ST_HORN: begin
        mul_a = pn;
        mul_b = (cnt_q[1:0] == 2'd3) ? {1'b0, x_q} : {1'b0, x2_q};
      end
      ST_D1: begin
        mul_a = 32'(cfg_i.pan_amp);
        mul_b = adif1;
      end
      ST_D2: begin
        mul_a = 32'(cfg_i.tilt_amp);
        mul_b = adif2;
      end
      ST_SQ1: begin
        mul_a = d1_q;
        mul_b = d1_q;
      end
      ST_SQ2: begin
        mul_a = d2_q;
        mul_b = d2_q;
      end
      ST_SQRT: begin
        sub_a = {1'b0, v_q};
        sub_b = {1'b0, res_q | bit_q};
      end
      ST_ADV0: begin
        if (m == 32'd0) begin
          mul_a = 32'(el_q);
          mul_b = SEC_TO_TURN;
        end else begin
          mul_a = 32'(cfg_i.speed);
          mul_b = 32'(el_q);
        end
      end
      ST_ADV1: begin
        mul_a = prod[31:0];
        mul_b = SPEED_K_Q4;
      end
      ST_ADV2: begin
        mul_a = ph_q;
        mul_b = SPEED_K_Q4;
      end
      ST_ADV3: begin
        sub_a = 65'(np_hi);
        sub_b = 65'(m);
      end
      ST_DIV: begin
        sub_a = 65'(r2);
        sub_b = 65'(m);
      end
      ST_TADV: begin
        mul_a = adv_q;
        mul_b = FREQ_FRAC32;
      end
      ST_A1: begin
        mul_a = 32'(cfg_i.pan_amp);
        mul_b = as4;
      end
      ST_A2: begin
        mul_a = 32'(cfg_i.tilt_amp);
        mul_b = as5;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // control state and phases
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= ST_IDLE;
      pan_ph_q  <= '0;
      tilt_ph_q <= '0;
      sl_q      <= '0;
      cnt_q     <= '0;
    end else begin
      st_q <= st_d;
      case (st_q)
        ST_IDLE: begin
          if (start_i) begin
            cnt_q <= '0;
            if (mode_i) begin
              pan_ph_q  <= to_pb(34'(RESTART_PAN32));
              tilt_ph_q <= to_pb(34'(QUARTER32));
              sl_q      <= 3'd4;
            end else if (elapsed_us_i < MIN_ELAPSED_US) begin
              sl_q <= 3'd4;
            end else begin
              sl_q <= 3'd0;
            end
          end
        end
        ST_SIN1: cnt_q <= '0;
        ST_HORN: cnt_q <= cnt_q + 5'd1;
        ST_SINF: begin
          if (sl_q != 3'd3 && sl_q != 3'd5) begin
            sl_q <= sl_q + 3'd1;
          end
        end
        ST_SQI:  cnt_q <= '0;
        ST_SQRT: cnt_q <= cnt_q + 5'd1;
        ST_ADV3: cnt_q <= '0;
        ST_DIV:  cnt_q <= cnt_q + 5'd1;
        ST_UPD: begin
          pan_ph_q  <= pan_ph_q + to_pb(34'(adv_q));
          tilt_ph_q <= tilt_ph_q + to_pb(tadv);
          sl_q      <= 3'd4;
        end
        default: ;
      endcase
    end
  end

  // item flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
      skip_q <= 1'b0;
    end else if (st_q == ST_IDLE && start_i) begin
      mode_q <= mode_i;
      skip_q <= !mode_i && (elapsed_us_i < MIN_ELAPSED_US);
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (st_q)
      ST_IDLE: el_q <= elapsed_us_i;
      ST_SIN0: begin
        x_q   <= x_new;
        neg_q <= ph_sel[31];
      end
      ST_SIN1: x2_q <= prod[60:30];
      ST_SINF: s_q[sl_q] <= neg_q ? -$signed(prod[61:30]) : $signed(prod[61:30]);
      ST_D2:   d1_q <= 32'((prod + 64'h8000) >> ANGLE_FRAC_BITS);
      ST_SQ1:  d2_q <= 32'((prod + 64'h8000) >> ANGLE_FRAC_BITS);
      ST_SQ2:  acc_q <= prod;
      ST_SQI: begin
        v_q   <= acc_q + prod;
        res_q <= '0;
        bit_q <= 64'd1 << 62;
      end
      ST_SQRT: begin
        if (ge) begin
          v_q   <= sub_r[63:0];
          res_q <= (res_q >> 1) | bit_q;
        end else begin
          res_q <= res_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end
      ST_ADVZ: adv_q <= 32'((prod + 64'h8000) >> 16);
      ST_ADV1: ph_q  <= {20'd0, prod[43:32]};
      ST_ADV2: acc_q <= prod;
      ST_ADV3: begin
        if (ge) begin
          adv_q <= '1;
        end else begin
          rem_q <= 32'(np_hi);
          quo_q <= np_lo;
        end
      end
      ST_DIV: begin
        rem_q <= ge ? sub_r[31:0] : r2lo;
        quo_q <= {quo_q[30:0], ge};
        if (cnt_q == 5'd31) begin
          adv_q <= {quo_q[30:0], ge};
        end
      end
      ST_A2: out_q.pan  <= sat20(pan_sum);
      ST_A3: begin
        out_q.tilt    <= sat20(tilt_sum);
        out_q.skipped <= skip_q;
      end
      default: ;
    endcase
  end

  assign stat_o.busy      = (st_q != ST_IDLE);
  assign stat_o.res_valid = (st_q == ST_DONE) && (mode_q || !mode_q);
  assign res_o            = out_q;

endmodule

/* hdl/constant_speed_lissajous_scan_top.sv */
// ----------------------------------------------------------------------------
// constant_speed_lissajous_scan_top
// Pan/tilt Lissajous scan generator holding the path speed near constant.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+---------------------------------
//  in       | input     | in_valid_i/in_stall_o| mode_i, elapsed_us_i
//  out      | output    | out_valid_o/out_stall_i | pan_angle_o, tilt_angle_o, skipped_o
//  cfg      | input     | cfg_we_i             | cfg_idx_i, cfg_wdata_i
//
//  an advancing item runs six sine evaluations, a 32-step square root and a
//  32-step divide on the shared units before the next acceptance; a zero speed
//  estimate or a clamped one skips the divide
//  restart and short items run two sine evaluations only
//  in_stall_o stays high from acceptance until the result enters the output
//  register; a stalled output holds the core in its final state
//  reset clears the phases and all configuration registers
// ----------------------------------------------------------------------------
module constant_speed_lissajous_scan_top import lsj_pkg::*; #(
  parameter int PHASE_BITS = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               mode_i,
  input  logic [19:0]        elapsed_us_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [19:0] pan_angle_o,
  output logic signed [19:0] tilt_angle_o,
  output logic               skipped_o,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [23:0]        cfg_wdata_i
);

  lsj_cfg_t  cfg_q;
  lsj_stat_t stat;
  lsj_res_t  res, out_q;
  logic      out_valid_q;
  logic      start, take;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_PAN_AMP:  cfg_q.pan_amp  <= cfg_wdata_i[18:0];
        REG_TILT_AMP: cfg_q.tilt_amp <= cfg_wdata_i[18:0];
        REG_PAN_OFF:  cfg_q.pan_off  <= cfg_wdata_i[19:0];
        REG_TILT_OFF: cfg_q.tilt_off <= cfg_wdata_i[19:0];
        REG_SPEED:    cfg_q.speed    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign in_stall_o = stat.busy;
  assign start      = in_valid_i && !stat.busy;
  assign take       = stat.res_valid && (!out_valid_q || !out_stall_i);

  lsj_core #(.PHASE_BITS(PHASE_BITS)) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .mode_i       (mode_i),
    .elapsed_us_i (elapsed_us_i),
    .cfg_i        (cfg_q),
    .res_take_i   (take),
    .stat_o       (stat),
    .res_o        (res)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (take) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      out_q <= res;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign pan_angle_o  = out_q.pan;
  assign tilt_angle_o = out_q.tilt;
  assign skipped_o    = out_q.skipped;

  // an accepted item keeps the core busy
  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |=> stat.busy)
    else $error("core not busy after item accepted");

  // a handed-over result shows at the output
  a_take_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |=> out_valid_o)
    else $error("result lost at output register");

  // a finished result only exists while the input side is held
  a_res_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.res_valid |-> in_stall_o)
    else $error("result offered while core idle");

endmodule
